/* hw/rtl/dads_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dads_pkg: shared types and constants for the dosage abs-diff sum block
// word formats, opcodes, register map and sequencer states
// ----------------------------------------------------------------------------
package dads_pkg;

    localparam int unsigned DOSAGE_W = 16;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned TOTAL_W  = 26;
    localparam int unsigned ENTRY_W  = DOSAGE_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // apb register map
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_REF_COUNT = 1'b0;   // word index, paddr[2]

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_SCORE = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                 op;
        logic [INDEX_W-1:0]  entry_index;
        logic [DOSAGE_W-1:0] dosage;
        logic                absent;
    } dads_in_t;

    typedef struct packed
    {
        logic [TOTAL_W-1:0] total;
        logic               no_data;
    } dads_out_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/dosage_abs_diff_sum_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dosage_abs_diff_sum_top: sum of absolute dosage differences
// reference store loaded word by word; a score word walks the entries in use
// through one shared subtract / saturating accumulate unit
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  in_data   (dads_in_t)
//  out       source     out_valid / out_stall out_data (dads_out_t)
//  apb       slave      psel/penable/pready  paddr, pwdata, prdata
//
//  a load word writes one store entry; a score word walks min(ref_count,
//  MAX_REFS) entries, one store read per cycle through the
//  single memory read port
//  a missing sample skips the walk; in_stall is high until the result is
//  placed in the output register, which then waits on out_stall by itself
//  rst_n clears control and ref_count; the store is not cleared
// ----------------------------------------------------------------------------
module dosage_abs_diff_sum_top #(
    parameter int unsigned MAX_REFS = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire dads_pkg::dads_in_t               in_data,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output dads_pkg::dads_out_t                   out_data,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dads_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [dads_pkg::PDATA_W-1:0]     pwdata,
    output logic      [dads_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int unsigned AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int unsigned CW = $clog2(MAX_REFS + 1);
    localparam int unsigned LW = (CW > dads_pkg::COUNT_W) ? CW : dads_pkg::COUNT_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [dads_pkg::COUNT_W-1:0] ref_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == dads_pkg::REG_REF_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            ref_count_reg <= pwdata[dads_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == dads_pkg::REG_REF_COUNT)
        begin
            prdata = dads_pkg::PDATA_W'(ref_count_reg);
        end
    end

    // entries in use, clipped to the store depth
    logic [LW-1:0] count_ext;
    logic [CW-1:0] limit;

    assign count_ext = LW'(ref_count_reg);
    assign limit     = (count_ext > LW'(MAX_REFS)) ? CW'(MAX_REFS) : CW'(count_ext);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    dads_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [dads_pkg::DOSAGE_W-1:0] sample_reg, sample_next;
    logic                          rd_vld_reg;
    logic                          diff_vld_reg;
    logic                          out_free;
    logic                          in_take;
    logic                          issue;
    logic                          load_wr;
    logic                          score_start;
    logic                          finish;
    logic                          run_done;

    assign out_free = !out_valid || !out_stall;
    assign in_take  = in_valid && !in_stall;
    assign run_done = (cnt_reg >= limit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dads_pkg::ST_IDLE:
            begin
                if (in_take && (in_data.op == dads_pkg::OP_SCORE))
                begin
                    state_next = in_data.absent ? dads_pkg::ST_FINISH : dads_pkg::ST_RUN;
                end
            end
            dads_pkg::ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = dads_pkg::ST_DRAIN;
                end
            end
            dads_pkg::ST_DRAIN:
            begin
                if (!rd_vld_reg && !diff_vld_reg)
                begin
                    state_next = dads_pkg::ST_FINISH;
                end
            end
            dads_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dads_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dads_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        issue       = 1'b0;
        load_wr     = 1'b0;
        score_start = 1'b0;
        finish      = 1'b0;
        cnt_next    = cnt_reg;
        sample_next = sample_reg;
        unique case (state_reg)
            dads_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_take)
                begin
                    if (in_data.op == dads_pkg::OP_LOAD)
                    begin
                        load_wr = (32'(in_data.entry_index) < 32'(MAX_REFS));
                    end
                    else
                    begin
                        score_start = 1'b1;
                        cnt_next    = '0;
                        sample_next = in_data.dosage;
                    end
                end
            end
            dads_pkg::ST_RUN:
            begin
                if (!run_done)
                begin
                    issue    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            dads_pkg::ST_DRAIN:
            begin
                issue = 1'b0;
            end
            dads_pkg::ST_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // reference store, one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [dads_pkg::ENTRY_W-1:0] store_mem [MAX_REFS];
    logic [dads_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            store_mem[AW'(in_data.entry_index)] <= {in_data.absent, in_data.dosage};
        end
        if (issue)
        begin
            rd_data_reg <= store_mem[cnt_reg[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // shared difference and saturating accumulate
    // ------------------------------------------------------------------
    logic [dads_pkg::DOSAGE_W-1:0] ref_dos;
    logic [dads_pkg::DOSAGE_W-1:0] diff_reg, diff_next;
    logic [dads_pkg::TOTAL_W-1:0]  acc_reg, acc_next;
    logic [dads_pkg::TOTAL_W:0]    acc_sum;
    logic                          no_data_reg, no_data_next;

    assign ref_dos = rd_data_reg[dads_pkg::DOSAGE_W-1:0];

    always_comb
    begin
        // missing reference entries add nothing
        if (rd_data_reg[dads_pkg::ENTRY_W-1])
        begin
            diff_next = '0;
        end
        else if (sample_reg > ref_dos)
        begin
            diff_next = sample_reg - ref_dos;
        end
        else
        begin
            diff_next = ref_dos - sample_reg;
        end
    end

    assign acc_sum = (dads_pkg::TOTAL_W + 1)'(acc_reg) + (dads_pkg::TOTAL_W + 1)'(diff_reg);

    always_comb
    begin
        acc_next     = acc_reg;
        no_data_next = no_data_reg;
        if (score_start)
        begin
            acc_next     = '0;
            no_data_next = in_data.absent;
        end
        else if (diff_vld_reg)
        begin
            acc_next = acc_sum[dads_pkg::TOTAL_W] ? dads_pkg::TOTAL_MAX
                                                  : acc_sum[dads_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dads_pkg::ST_IDLE;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            diff_vld_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= issue;
            diff_vld_reg <= rd_vld_reg;
            if (finish)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        acc_reg     <= acc_next;
        no_data_reg <= no_data_next;
        if (rd_vld_reg)
        begin
            diff_reg <= diff_next;
        end
        if (finish)
        begin
            out_data.total   <= acc_reg;
            out_data.no_data <= no_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_read_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> ($past(state_reg) == dads_pkg::ST_RUN))
        else $error("store read issued outside the walk");

    a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dads_pkg::ST_FINISH) |-> (!rd_vld_reg && !diff_vld_reg))
        else $error("result taken with differences still in flight");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dads_pkg::ST_RUN) |-> (cnt_reg <= CW'(MAX_REFS)))
        else $error("walk counter beyond store depth");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.no_data) |-> (out_data.total == '0))
        else $error("missing sample word carries a nonzero total");

endmodule
`default_nettype wire
